FILE: hdl/parrinello_rahman_box_coupling_assert.svh
// ---------------------------------------------------------------------------
// box coupling assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ---------------------------------------------------------------------------
`ifndef PARRINELLO_RAHMAN_BOX_COUPLING_ASSERT_SVH
`define PARRINELLO_RAHMAN_BOX_COUPLING_ASSERT_SVH

// same-cycle implication
`define PRBC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box coupling check failed");

// next-cycle implication
`define PRBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box coupling check failed");

`endif

FILE: hdl/prbc_pkg.sv
// ---------------------------------------------------------------------------
// prbc_pkg
// types, codes and helpers shared by the box coupling block
// ---------------------------------------------------------------------------
package prbc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE          = 80;

  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pressure_x;
    logic signed [31:0] pressure_y;
    logic signed [31:0] pressure_z;
    logic        [30:0] load_side_x;
    logic        [30:0] load_side_y;
    logic        [30:0] load_side_z;
  } prbc_in_t;

  typedef struct packed {
    logic signed [31:0] lambda_x;
    logic signed [31:0] lambda_y;
    logic signed [31:0] lambda_z;
    logic        [30:0] new_side_x;
    logic        [30:0] new_side_y;
    logic        [30:0] new_side_z;
  } prbc_out_t;

  typedef enum logic [2:0] {
    REG_STEP_SIZE,
    REG_GROUP_MASKS,
    REG_GAIN_A,
    REG_GAIN_B,
    REG_GAIN_C,
    REG_REF_A,
    REG_REF_B,
    REG_REF_C
  } prbc_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_AVG_WAIT,
    S_MUL_GAIN,
    S_MUL_AREA,
    S_AREA_WB,
    S_MUL_T2,
    S_DIV_DELTA,
    S_WAIT_DELTA,
    S_DIV_LAM,
    S_WAIT_LAM,
    S_OUT
  } prbc_state_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] den;
  } prbc_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } prbc_div_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] hi;
    logic signed [WIDE-1:0] lo;
    hi = WIDE'(64'sd2147483647);
    lo = -WIDE'(64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: hdl/prbc_mul.sv
// ---------------------------------------------------------------------------
// prbc_mul
// shared signed multiplier with registered product
// ---------------------------------------------------------------------------
module prbc_mul import prbc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

FILE: hdl/prbc_div.sv
// ---------------------------------------------------------------------------
// prbc_div
// serial restoring divider, one quotient bit a cycle, truncating, saturated
// ---------------------------------------------------------------------------
module prbc_div import prbc_pkg::*; #(
  parameter int MAG_W = 33 + FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  prbc_div_req_t    req,
  input  logic [MAG_W-1:0] mag,
  output prbc_div_res_t    res
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic                   busy_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [31:0]            rem_r;
  logic [MAG_W-1:0]       q_r;
  logic                   neg_r;
  logic [31:0]            den_r;
  logic                   done_r;
  logic signed [31:0]     quo_r;

  logic [32:0]            sh;
  logic [32:0]            trial;
  logic                   fits;
  logic signed [WIDE-1:0] qv;
  logic signed [WIDE-1:0] sv;

  always_comb begin
    sh    = {rem_r, q_r[MAG_W-1]};
    trial = sh - {1'b0, den_r};
    fits  = sh >= {1'b0, den_r};
    qv    = $signed(WIDE'(q_r));
    sv    = neg_r ? -qv : qv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MAG_W);
      end else if (busy_r && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      q_r   <= mag;
      neg_r <= req.neg;
      den_r <= req.den;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= fits ? trial[31:0] : sh[31:0];
      q_r   <= {q_r[MAG_W-2:0], fits};
    end else if (busy_r) begin
      quo_r <= sat32(sv);
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

FILE: hdl/parrinello_rahman_box_coupling.sv
// ---------------------------------------------------------------------------
// parrinello_rahman_box_coupling
// orthorhombic box pressure coupling in signed fixed point
// ---------------------------------------------------------------------------
// One request at a time. A load request is taken while idle, loads the sides,
// clears the velocities and gives no result. A step request walks a sequencer
// over one shared multiplier and one serial divider: up to three group
// averages, then per direction three multiplies and a divide for the velocity,
// then per direction a divide for lambda alongside the side update multiply.
// The divider makes one quotient bit a cycle over 33+FRACTION_BITS bits, and
// each divide holds the sequencer until it is done. With the default
// FRACTION_BITS the format is Q16.16. The result is held with out_valid while
// out_stall is high. in_stall stays high from acceptance of a step until its
// result is taken. Configuration writes are registered and are expected only
// while the block is idle.
// ---------------------------------------------------------------------------
module parrinello_rahman_box_coupling import prbc_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  prbc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output prbc_out_t   out_data,
  input  logic        cfg_we,
  input  prbc_reg_t   cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int MAG_W = 33 + FRACTION_BITS;
  localparam logic [30:0] ONE_SIDE = 31'(1) << FRACTION_BITS;

  // configuration
  logic        [30:0] step_r;
  logic        [8:0]  masks_r;
  logic signed [31:0] gain_r [3];
  logic signed [31:0] refp_r [3];

  // box state
  logic        [30:0] side_r [3];
  logic signed [31:0] vel_r  [3];
  logic signed [31:0] vold_r [3];
  logic signed [31:0] lam_r  [3];

  // per request working set
  logic signed [31:0] p_r    [3];
  logic signed [31:0] gsel_r [3];
  logic signed [31:0] rsel_r [3];
  logic signed [31:0] t1_r;
  logic signed [31:0] area_r;
  logic        [1:0]  d_r;
  logic        [1:0]  g_r;
  prbc_state_t        state_r, state_nxt;

  // shared units
  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  prbc_div_req_t      div_req;
  logic [MAG_W-1:0]   div_mag;
  prbc_div_res_t      div_res;

  // helpers
  logic        [2:0]  cur_mask;
  logic        [1:0]  n_members;
  logic signed [33:0] grp_sum;
  logic        [30:0] longest;
  logic        [30:0] s1, s2;
  logic signed [31:0] diff;
  logic signed [WIDE-1:0] prod_sh;
  logic signed [31:0] prod_sat;
  logic signed [WIDE-1:0] num_w;
  logic signed [WIDE-1:0] num_abs;
  logic signed [32:0] vsum;
  logic signed [WIDE-1:0] ns_w;
  logic        [30:0] ns_clamped;
  logic signed [31:0] vnew;
  logic signed [31:0] gain_pick [3];
  logic signed [31:0] ref_pick  [3];

  logic step_acc, load_acc;

  assign step_acc = in_valid && !in_stall && in_data.action == ACT_STEP;
  assign load_acc = in_valid && !in_stall && in_data.action == ACT_LOAD;

  prbc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  prbc_div #(.MAG_W(MAG_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .mag   (div_mag),
    .res   (div_res)
  );

  // gain and reference per direction: the last group naming it wins
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      gain_pick[d] = '0;
      ref_pick[d]  = '0;
      for (int g = 0; g < 3; g++) begin
        if (masks_r[3*g+d]) begin
          gain_pick[d] = gain_r[g];
          ref_pick[d]  = refp_r[g];
        end
      end
    end
  end

  // group being averaged
  always_comb begin
    case (g_r)
      2'd0:    cur_mask = masks_r[2:0];
      2'd1:    cur_mask = masks_r[5:3];
      default: cur_mask = masks_r[8:6];
    endcase
    n_members = 2'(cur_mask[0]) + 2'(cur_mask[1]) + 2'(cur_mask[2]);
    grp_sum   = (cur_mask[0] ? 34'(p_r[0]) : 34'sd0)
              + (cur_mask[1] ? 34'(p_r[1]) : 34'sd0)
              + (cur_mask[2] ? 34'(p_r[2]) : 34'sd0);
  end

  // geometry of the current direction
  always_comb begin
    longest = side_r[0];
    if (side_r[1] > longest) longest = side_r[1];
    if (side_r[2] > longest) longest = side_r[2];
    case (d_r)
      2'd0:    begin s1 = side_r[1]; s2 = side_r[2]; end
      2'd1:    begin s1 = side_r[2]; s2 = side_r[0]; end
      default: begin s1 = side_r[0]; s2 = side_r[1]; end
    endcase
    diff     = sat32(WIDE'(p_r[d_r]) - WIDE'(rsel_r[d_r]));
    prod_sh  = WIDE'(prod) >>> FRACTION_BITS;
    prod_sat = sat32(prod_sh);
    vsum     = 33'(vel_r[d_r]) + 33'(vold_r[d_r]);
    vnew     = sat32(WIDE'(vel_r[d_r]) + WIDE'(div_res.quo));
    ns_w     = $signed(WIDE'(side_r[d_r])) + prod_sh;
    if (ns_w < WIDE'(1))
      ns_clamped = 31'd1;
    else if (ns_w > WIDE'(64'sd2147483647))
      ns_clamped = 31'h7fffffff;
    else
      ns_clamped = ns_w[30:0];
  end

  // sequencer and unit operand selection
  always_comb begin
    state_nxt   = state_r;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    num_w       = '0;
    case (state_r)
      S_IDLE: begin
        if (step_acc) state_nxt = S_AVG;
      end
      S_AVG: begin
        // only groups of two or more members need the divider
        if (n_members > 2'd1) begin
          div_req.start = 1'b1;
          div_req.den   = 32'(n_members);
          num_w         = WIDE'(grp_sum);
          state_nxt     = S_AVG_WAIT;
        end else if (g_r == 2'd2) begin
          state_nxt = S_MUL_GAIN;
        end
      end
      S_AVG_WAIT: begin
        if (div_res.done) state_nxt = (g_r == 2'd2) ? S_MUL_GAIN : S_AVG;
      end
      S_MUL_GAIN: begin
        mul_en    = 1'b1;
        mul_a     = 33'(gsel_r[d_r]);
        mul_b     = 33'(diff);
        state_nxt = S_MUL_AREA;
      end
      S_MUL_AREA: begin
        mul_en    = 1'b1;
        mul_a     = $signed({2'b00, s1});
        mul_b     = $signed({2'b00, s2});
        state_nxt = S_AREA_WB;
      end
      S_AREA_WB: begin
        state_nxt = S_MUL_T2;
      end
      S_MUL_T2: begin
        mul_en    = 1'b1;
        mul_a     = 33'(t1_r);
        mul_b     = 33'(area_r);
        state_nxt = S_DIV_DELTA;
      end
      S_DIV_DELTA: begin
        div_req.start = 1'b1;
        div_req.den   = {1'b0, longest};
        num_w         = WIDE'(prod_sat) <<< FRACTION_BITS;
        state_nxt     = S_WAIT_DELTA;
      end
      S_WAIT_DELTA: begin
        if (div_res.done) state_nxt = (d_r == 2'd2) ? S_DIV_LAM : S_MUL_GAIN;
      end
      S_DIV_LAM: begin
        div_req.start = 1'b1;
        div_req.den   = {1'b0, side_r[d_r]};
        num_w         = WIDE'(vsum) <<< FRACTION_BITS;
        mul_en        = 1'b1;
        mul_a         = $signed({2'b00, step_r});
        mul_b         = 33'(vel_r[d_r]);
        state_nxt     = S_WAIT_LAM;
      end
      S_WAIT_LAM: begin
        if (div_res.done) state_nxt = (d_r == 2'd2) ? S_OUT : S_DIV_LAM;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    div_req.neg = num_w < 0;
    num_abs     = div_req.neg ? -num_w : num_w;
    div_mag     = num_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // loop indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= '0;
      d_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          g_r <= '0;
          d_r <= '0;
        end
        S_AVG: begin
          if (n_members <= 2'd1 && g_r != 2'd2) g_r <= g_r + 1'b1;
        end
        S_AVG_WAIT: begin
          if (div_res.done && g_r != 2'd2) g_r <= g_r + 1'b1;
        end
        S_WAIT_DELTA, S_WAIT_LAM: begin
          if (div_res.done) d_r <= (d_r == 2'd2) ? 2'd0 : d_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ONE_SIDE;
      masks_r <= '0;
      for (int g = 0; g < 3; g++) begin
        gain_r[g] <= '0;
        refp_r[g] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_SIZE:   step_r    <= cfg_wdata[30:0];
        REG_GROUP_MASKS: masks_r   <= cfg_wdata[8:0];
        REG_GAIN_A:      gain_r[0] <= cfg_wdata;
        REG_GAIN_B:      gain_r[1] <= cfg_wdata;
        REG_GAIN_C:      gain_r[2] <= cfg_wdata;
        REG_REF_A:       refp_r[0] <= cfg_wdata;
        REG_REF_B:       refp_r[1] <= cfg_wdata;
        REG_REF_C:       refp_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // box state: sides and velocities
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < 3; d++) begin
        side_r[d] <= ONE_SIDE;
        vel_r[d]  <= '0;
      end
    end else if (load_acc) begin
      // a zero side is clamped to one lsb so later divides stay defined
      side_r[0] <= (in_data.load_side_x == '0) ? 31'd1 : in_data.load_side_x;
      side_r[1] <= (in_data.load_side_y == '0) ? 31'd1 : in_data.load_side_y;
      side_r[2] <= (in_data.load_side_z == '0) ? 31'd1 : in_data.load_side_z;
      for (int d = 0; d < 3; d++) vel_r[d] <= '0;
    end else if (state_r == S_WAIT_DELTA && div_res.done) begin
      vel_r[d_r] <= vnew;
    end else if (state_r == S_WAIT_LAM && div_res.done) begin
      side_r[d_r] <= ns_clamped;
    end
  end

  // working registers of a step
  always_ff @(posedge clk) begin
    if (step_acc) begin
      p_r[0] <= in_data.pressure_x;
      p_r[1] <= in_data.pressure_y;
      p_r[2] <= in_data.pressure_z;
      for (int d = 0; d < 3; d++) begin
        gsel_r[d] <= gain_pick[d];
        rsel_r[d] <= ref_pick[d];
      end
    end
    if (state_r == S_AVG_WAIT && div_res.done) begin
      for (int d = 0; d < 3; d++) begin
        if (cur_mask[d]) p_r[d] <= div_res.quo;
      end
    end
    if (state_r == S_MUL_AREA) t1_r <= prod_sat;
    if (state_r == S_AREA_WB) area_r <= prod_sat;
    if (state_r == S_WAIT_DELTA && div_res.done) vold_r[d_r] <= vel_r[d_r];
    if (state_r == S_WAIT_LAM && div_res.done) lam_r[d_r] <= div_res.quo;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    out_data.lambda_x   = lam_r[0];
    out_data.lambda_y   = lam_r[1];
    out_data.lambda_z   = lam_r[2];
    out_data.new_side_x = side_r[0];
    out_data.new_side_y = side_r[1];
    out_data.new_side_z = side_r[2];
  end

endmodule

FILE: hdl/prbc_checker.sv
// ---------------------------------------------------------------------------
// prbc_checker
// port level checks of the box coupling block, bound to the top level
// ---------------------------------------------------------------------------
`include "parrinello_rahman_box_coupling_assert.svh"

module prbc_checker import prbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input prbc_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input prbc_out_t out_data
);

  `PRBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `PRBC_ASSERT_NEXT(a_step_busy, in_valid && !in_stall && in_data.action == ACT_STEP, in_stall)
  `PRBC_ASSERT_SAME(a_one_open, out_valid, in_stall)
  `PRBC_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && in_data.action == ACT_LOAD,
                    !out_valid)

endmodule

bind parrinello_rahman_box_coupling prbc_checker u_prbc_checker (.*);

FILE: tb/parrinello_rahman_box_coupling_tb.sv
// ---------------------------------------------------------------------------
// parrinello_rahman_box_coupling_tb
// self-checking bench for the box coupling block: a queue of requests is
// driven with random gaps, a behavioural model predicts each step result and
// the monitor compares every returned result field by field
// ---------------------------------------------------------------------------
module parrinello_rahman_box_coupling_tb;
  import prbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  prbc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  prbc_out_t   out_data;
  logic        cfg_we;
  prbc_reg_t   cfg_index;
  logic [31:0] cfg_wdata;

  parrinello_rahman_box_coupling uut (.*);

  // model copy of the registers and the box state
  longint dt_q;
  logic [8:0] masks_q;
  longint gain_q [3];
  longint pref_q [3];
  longint side_q [3];
  longint vel_q [3];

  prbc_in_t  pending_req [$];
  prbc_out_t expected_res [$];

  int  fails;
  int  idle_cycles;
  int  steps_sent;
  int  results_seen;
  bit  calm;          // no idling while set
  bit  in_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor division by 2^FB
  function automatic longint fl_shift(longint v);
    return v >>> FB;
  endfunction

  // model of a register write
  function automatic void model_cfg(prbc_reg_t idx, logic [31:0] v);
    case (idx)
      REG_STEP_SIZE:   dt_q = longint'(v[30:0]);
      REG_GROUP_MASKS: masks_q = v[8:0];
      REG_GAIN_A:      gain_q[0] = longint'($signed(v));
      REG_GAIN_B:      gain_q[1] = longint'($signed(v));
      REG_GAIN_C:      gain_q[2] = longint'($signed(v));
      REG_REF_A:       pref_q[0] = longint'($signed(v));
      REG_REF_B:       pref_q[1] = longint'($signed(v));
      default:         pref_q[2] = longint'($signed(v));
    endcase
  endfunction

  // box update for one accepted request, pushes the expected result of a step
  function automatic void predict_box(prbc_in_t r);
    longint p [3];
    longint g [3];
    longint rf [3];
    longint vo [3];
    longint lam [3];
    longint sum, n, avg, lng, diff, t1, area, t2, dl, ns;
    logic [2:0] m;
    prbc_out_t o;
    if (r.action == ACT_LOAD) begin
      side_q[0] = longint'(r.load_side_x);
      side_q[1] = longint'(r.load_side_y);
      side_q[2] = longint'(r.load_side_z);
      for (int d = 0; d < 3; d++) begin
        if (side_q[d] < 1) side_q[d] = 1;
        vel_q[d] = 0;
      end
      return;
    end
    p[0] = longint'(r.pressure_x);
    p[1] = longint'(r.pressure_y);
    p[2] = longint'(r.pressure_z);
    for (int d = 0; d < 3; d++) begin
      g[d] = 0;
      rf[d] = 0;
    end
    // groups in order, later groups override gain and target
    for (int k = 0; k < 3; k++) begin
      m = masks_q[3*k +: 3];
      sum = 0;
      n = 0;
      for (int d = 0; d < 3; d++)
        if (m[d]) begin
          sum += p[d];
          n++;
          g[d] = gain_q[k];
          rf[d] = pref_q[k];
        end
      if (n > 1) begin
        avg = sum / n;
        for (int d = 0; d < 3; d++) if (m[d]) p[d] = avg;
      end
    end
    lng = side_q[0];
    if (side_q[1] > lng) lng = side_q[1];
    if (side_q[2] > lng) lng = side_q[2];
    for (int d = 0; d < 3; d++) begin
      diff = clip32(p[d] - rf[d]);
      t1 = clip32(fl_shift(g[d] * diff));
      area = clip32(fl_shift(side_q[(d+1)%3] * side_q[(d+2)%3]));
      t2 = clip32(fl_shift(t1 * area));
      dl = clip32((t2 * (64'sd1 << FB)) / lng);
      vo[d] = vel_q[d];
      vel_q[d] = clip32(vo[d] + dl);
    end
    for (int d = 0; d < 3; d++) begin
      lam[d] = clip32(((vel_q[d] + vo[d]) * (64'sd1 << FB)) / side_q[d]);
      ns = side_q[d] + fl_shift(dt_q * vel_q[d]);
      if (ns < 1) ns = 1;
      if (ns > 64'sd2147483647) ns = 64'sd2147483647;
      side_q[d] = ns;
    end
    o.lambda_x = lam[0][31:0];
    o.lambda_y = lam[1][31:0];
    o.lambda_z = lam[2][31:0];
    o.new_side_x = side_q[0][30:0];
    o.new_side_y = side_q[1][30:0];
    o.new_side_z = side_q[2][30:0];
    expected_res.push_back(o);
  endfunction

  // driver: one request at a time from the queue, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      predict_box(in_data);
      if (in_data.action == ACT_STEP) steps_sent++;
      void'(pending_req.pop_front());
      if (pending_req.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        in_data <= pending_req[0];
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_req.size() > 0 &&
                 (calm || $urandom_range(99) >= 38)) begin
      in_valid <= 1'b1;
      in_data  <= pending_req[0];
    end
  end

  // monitor: random back-pressure and field checks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $error("result with nothing expected");
          fails++;
        end else begin
          prbc_out_t e;
          e = expected_res.pop_front();
          if (out_data.lambda_x !== e.lambda_x) begin
            $error("lambda_x exp %h got %h", e.lambda_x, out_data.lambda_x); fails++;
          end
          if (out_data.lambda_y !== e.lambda_y) begin
            $error("lambda_y exp %h got %h", e.lambda_y, out_data.lambda_y); fails++;
          end
          if (out_data.lambda_z !== e.lambda_z) begin
            $error("lambda_z exp %h got %h", e.lambda_z, out_data.lambda_z); fails++;
          end
          if (out_data.new_side_x !== e.new_side_x) begin
            $error("new_side_x exp %h got %h", e.new_side_x, out_data.new_side_x); fails++;
          end
          if (out_data.new_side_y !== e.new_side_y) begin
            $error("new_side_y exp %h got %h", e.new_side_y, out_data.new_side_y); fails++;
          end
          if (out_data.new_side_z !== e.new_side_z) begin
            $error("new_side_z exp %h got %h", e.new_side_z, out_data.new_side_z); fails++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // each write raises the strobe, then drops it and idles before the task returns
  task automatic write_reg(prbc_reg_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cfg(idx, v);
    @(posedge clk);
  endtask

  // wait until every queued request is in and every result has returned
  task automatic drain;
    while (pending_req.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic prbc_in_t make_step(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    prbc_in_t r;
    r = '0;
    r.action = ACT_STEP;
    r.pressure_x = px;
    r.pressure_y = py;
    r.pressure_z = pz;
    // unused load fields carry junk
    r.load_side_x = 31'($urandom);
    r.load_side_y = 31'($urandom);
    r.load_side_z = 31'($urandom);
    return r;
  endfunction

  function automatic prbc_in_t make_load(logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
    prbc_in_t r;
    r = '0;
    r.action = ACT_LOAD;
    r.pressure_x = $urandom;
    r.pressure_y = $urandom;
    r.pressure_z = $urandom;
    r.load_side_x = sx;
    r.load_side_y = sy;
    r.load_side_z = sz;
    return r;
  endfunction

  // pressures mostly near a target, sometimes anywhere
  function automatic logic [31:0] rnd_press();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(20 << FB)) - (10 << FB));
  endfunction

  function automatic logic [30:0] rnd_side();
    case ($urandom_range(9))
      0:       return 31'($urandom);
      1:       return 31'($urandom_range(3));
      default: return 31'($urandom_range(1 << FB, 8 << FB));
    endcase
  endfunction

  // random phase: fresh registers, then loads and steps
  task automatic random_phase(int n_items);
    prbc_reg_t ri;
    write_reg(REG_STEP_SIZE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 12));
    write_reg(REG_GROUP_MASKS, $urandom_range(511));
    for (int k = 0; k < 3; k++) begin
      ri = prbc_reg_t'(REG_GAIN_A + k);
      write_reg(ri, ($urandom_range(4) == 0) ? $urandom
                : 32'($signed($urandom_range(1 << 14)) - (1 << 13)));
      ri = prbc_reg_t'(REG_REF_A + k);
      write_reg(ri, ($urandom_range(4) == 0) ? $urandom
                : 32'($signed($urandom_range(4 << FB)) - (2 << FB)));
    end
    pending_req.push_back(make_load(rnd_side(), rnd_side(), rnd_side()));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(15) == 0)
        pending_req.push_back(make_load(rnd_side(), rnd_side(), rnd_side()));
      else
        pending_req.push_back(make_step(rnd_press(), rnd_press(), rnd_press()));
    end
    drain();
  endtask

  initial begin
    fails = 0;
    steps_sent = 0;
    results_seen = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_STEP_SIZE;
    cfg_wdata = '0;
    // model reset state
    dt_q = 64'sd1 << FB;
    masks_q = '0;
    for (int d = 0; d < 3; d++) begin
      gain_q[d] = 0;
      pref_q[d] = 0;
      side_q[d] = 64'sd1 << FB;
      vel_q[d] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, then groups, overlaps and extremes
    pending_req.push_back(make_step(32'h7fffffff, 32'h80000000, 32'h0));
    drain();
    write_reg(REG_STEP_SIZE, 32'h7fffffff);
    write_reg(REG_GROUP_MASKS, 32'(9'b100_011_111));   // all, then xy, then z
    write_reg(REG_GAIN_A, 32'h7fffffff);
    write_reg(REG_GAIN_B, 32'h80000000);
    write_reg(REG_GAIN_C, 32'h00010000);
    write_reg(REG_REF_A, 32'h80000000);
    write_reg(REG_REF_B, 32'h7fffffff);
    write_reg(REG_REF_C, 32'h00008000);
    pending_req.push_back(make_load(31'h0, 31'h7fffffff, 31'h1));   // zero side clamps
    pending_req.push_back(make_step(32'h7fffffff, 32'h7fffffff, 32'h80000000));
    pending_req.push_back(make_step(32'h80000000, 32'h00000000, 32'h7fffffff));
    pending_req.push_back(make_load(31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    pending_req.push_back(make_step(32'hffffffff, 32'h1, 32'h80000000));
    pending_req.push_back(make_load(31'h10000, 31'h20000, 31'h30000));
    pending_req.push_back(make_step(32'h00050000, 32'hfffb0000, 32'h00010000));
    drain();
    write_reg(REG_STEP_SIZE, 32'h0);                     // sides must not move
    write_reg(REG_GROUP_MASKS, 32'(9'b000_000_010));   // y only, x and z uncoupled
    write_reg(REG_GAIN_A, 32'h00000100);
    pending_req.push_back(make_step(32'h00020000, 32'h00030000, 32'h00040000));
    pending_req.push_back(make_step(32'h80000000, 32'h80000000, 32'h80000000));
    drain();
    write_reg(REG_STEP_SIZE, 32'h1);
    write_reg(REG_GROUP_MASKS, 32'h1ff);
    pending_req.push_back(make_step(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    drain();

    // random: phases with fresh settings, one with no idling at all
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4);
      random_phase(100);
    end
    calm = 1'b0;

    $display("covered %0d step requests and %0d checked results over ten register settings",
             steps_sent, results_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
